### src/index_to_charset_string_assert.svh
// Assertion macros for the conversion block's top-level RTL file.
`ifndef INDEX_TO_CHARSET_STRING_ASSERT_SVH
`define INDEX_TO_CHARSET_STRING_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ITCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ITCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/itcs_pkg.sv
// Types and constants for the index to charset string converter.
`default_nettype none

package itcs_pkg;

  localparam int IDX_W          = 64;
  localparam int CELL_W         = 8;
  localparam int NUM_CELLS      = IDX_W / CELL_W;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int ALPHA_WORDS    = 6;
  localparam int BYTES_PER_WORD = IDX_W / CHAR_W;
  localparam int ALPHA_CHARS    = ALPHA_WORDS * BYTES_PER_WORD;
  localparam int MAX_LEN_N      = 16;
  localparam int LEN_W          = $clog2(MAX_LEN_N + 1);
  localparam int POS_W          = $clog2(MAX_LEN_N);
  localparam int CFG_IDX_W      = 3;

  localparam logic [LEN_W-1:0]   MAX_LEN        = LEN_W'(MAX_LEN_N);
  localparam logic [RADIX_W-1:0] RADIX_MIN      = RADIX_W'(1);
  localparam logic [RADIX_W-1:0] RADIX_MAX      = RADIX_W'(ALPHA_CHARS);
  localparam logic [RADIX_W-1:0] ALPHA_SIZE_RST = RADIX_W'(26);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_SIZE  = 3'd0,
    REG_ALPHA_WORD0 = 3'd1,
    REG_ALPHA_WORD1 = 3'd2,
    REG_ALPHA_WORD2 = 3'd3,
    REG_ALPHA_WORD3 = 3'd4,
    REG_ALPHA_WORD4 = 3'd5,
    REG_ALPHA_WORD5 = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] key_index;
    logic [LEN_W-1:0] string_length;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  char_position;
    logic              is_last;
  } out_t;

  // Partial remainder travelling down the chain, one division per token.
  typedef struct packed {
    logic               vld;
    logic [RADIX_W-1:0] rem;
  } link_t;

  typedef struct packed {
    logic               load;
    logic               feed;
    logic [RADIX_W-1:0] radix;
  } ctl_t;

endpackage

`default_nettype wire

### src/itcs_cell.sv
// One divider cell: holds a byte of the running index, divides it by the radix.
`default_nettype none

module itcs_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  itcs_pkg::ctl_t               ctl,
  input  wire [itcs_pkg::CELL_W-1:0]   load_byte,
  input  itcs_pkg::link_t              up,
  output itcs_pkg::link_t              down
);

  logic [itcs_pkg::CELL_W-1:0]  byte_r;
  logic [itcs_pkg::CELL_W-1:0]  quo;
  logic [itcs_pkg::RADIX_W-1:0] rem_out;
  itcs_pkg::link_t              down_r;

  // Restoring division of {remainder from above, byte} by the radix, msb first.
  always_comb begin
    logic [itcs_pkg::RADIX_W:0] trial;
    logic [itcs_pkg::RADIX_W:0] diff;
    logic [itcs_pkg::RADIX_W-1:0] rem;
    rem = up.rem;
    quo = '0;
    for (int i = itcs_pkg::CELL_W - 1; i >= 0; i--) begin
      trial = {rem, byte_r[i]};
      diff  = trial - {1'b0, ctl.radix};
      if (trial >= {1'b0, ctl.radix}) begin
        quo[i] = 1'b1;
        rem    = diff[itcs_pkg::RADIX_W-1:0];
      end else begin
        rem    = trial[itcs_pkg::RADIX_W-1:0];
      end
    end
    rem_out = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r.vld <= 1'b0;
    end else begin
      down_r.vld <= up.vld;
    end
    down_r.rem <= rem_out;
    if (ctl.load) begin
      byte_r <= load_byte;
    end else if (up.vld) begin
      byte_r <= quo;
    end
  end

  assign down = down_r;

endmodule

`default_nettype wire

### src/itcs_chain.sv
// Row of divider cells, most significant byte at the head of the chain.
`default_nettype none

module itcs_chain (
  input  wire                          clk,
  input  wire                          rst_n,
  input  itcs_pkg::ctl_t               ctl,
  input  wire [itcs_pkg::IDX_W-1:0]    key_index,
  output itcs_pkg::link_t              tail
);

  itcs_pkg::link_t lnk [itcs_pkg::NUM_CELLS:0];

  // Head of the chain starts each division with a zero remainder.
  assign lnk[itcs_pkg::NUM_CELLS].vld = ctl.feed;
  assign lnk[itcs_pkg::NUM_CELLS].rem = '0;

  for (genvar j = 0; j < itcs_pkg::NUM_CELLS; j++) begin : g_cell
    itcs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_byte (key_index[j*itcs_pkg::CELL_W +: itcs_pkg::CELL_W]),
      .up        (lnk[j+1]),
      .down      (lnk[j])
    );
  end

  assign tail = lnk[0];

endmodule

`default_nettype wire

### src/index_to_charset_string.sv
// Top level: writes a 64-bit index as a string over a configured alphabet.
//
// An item is taken when start is high and busy low; busy then stays high until
// the last character has been shown. Characters come out one per cycle on
// consecutive cycles, last position first, with out_valid high for exactly one
// cycle each and no way to hold them off. A length of 0 gives no characters and
// does not raise busy. The path runs through the eight-cell divider chain and
// then the output register: each cell divides one byte of the index per cycle,
// and a new division can enter the chain before the last one has left it.
// The alphabet registers may be written at any time the block is not busy.
`default_nettype none
`include "index_to_charset_string_assert.svh"

module index_to_charset_string (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  itcs_pkg::in_t                    in_data,
  output logic                             out_valid,
  output itcs_pkg::out_t                   out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [itcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [itcs_pkg::IDX_W-1:0]        cfg_data
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                                 state_r;
  logic [itcs_pkg::LEN_W-1:0]             len_r;
  logic [itcs_pkg::LEN_W-1:0]             issue_cnt_r;
  logic [itcs_pkg::LEN_W-1:0]             out_cnt_r;
  logic                                   out_valid_r;
  itcs_pkg::out_t                         out_data_r;
  logic [itcs_pkg::RADIX_W-1:0]           size_r;
  logic [itcs_pkg::ALPHA_WORDS-1:0][itcs_pkg::BYTES_PER_WORD-1:0][itcs_pkg::CHAR_W-1:0]
                                          alpha_r;

  logic                                   accept;
  logic [itcs_pkg::LEN_W-1:0]             len_sat;
  logic [itcs_pkg::LEN_W-1:0]             len_m1;
  logic [itcs_pkg::LEN_W-1:0]             pos_full;
  itcs_pkg::ctl_t                         ctl;
  itcs_pkg::link_t                        tail;

  assign accept    = start && !busy;
  assign busy      = (state_r == ST_RUN);
  assign cfg_ready = 1'b1;

  assign len_sat  = (in_data.string_length > itcs_pkg::MAX_LEN) ?
                    itcs_pkg::MAX_LEN : in_data.string_length;
  assign len_m1   = len_r - itcs_pkg::LEN_W'(1);
  assign pos_full = len_m1 - out_cnt_r;

  always_comb begin
    ctl.load = accept;
    ctl.feed = (state_r == ST_RUN) && (issue_cnt_r < len_r);
    if (size_r == '0) begin
      ctl.radix = itcs_pkg::RADIX_MIN;
    end else if (size_r > itcs_pkg::RADIX_MAX) begin
      ctl.radix = itcs_pkg::RADIX_MAX;
    end else begin
      ctl.radix = size_r;
    end
  end

  itcs_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .key_index (in_data.key_index),
    .tail      (tail)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= itcs_pkg::ALPHA_SIZE_RST;
      alpha_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        itcs_pkg::REG_ALPHA_SIZE: begin
          size_r <= cfg_data[itcs_pkg::RADIX_W-1:0];
        end
        itcs_pkg::REG_ALPHA_WORD0, itcs_pkg::REG_ALPHA_WORD1,
        itcs_pkg::REG_ALPHA_WORD2, itcs_pkg::REG_ALPHA_WORD3,
        itcs_pkg::REG_ALPHA_WORD4, itcs_pkg::REG_ALPHA_WORD5: begin
          alpha_r[cfg_index - itcs_pkg::CFG_IDX_W'(itcs_pkg::REG_ALPHA_WORD0)] <= cfg_data;
        end
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_cnt_r <= '0;
      out_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (len_sat != '0)) begin
            state_r <= ST_RUN;
          end
          issue_cnt_r <= '0;
          out_cnt_r   <= '0;
        end
        ST_RUN: begin
          if (ctl.feed) begin
            issue_cnt_r <= issue_cnt_r + itcs_pkg::LEN_W'(1);
          end
          if (tail.vld) begin
            out_cnt_r <= out_cnt_r + itcs_pkg::LEN_W'(1);
          end
          if (out_valid_r && out_data_r.is_last) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      out_valid_r <= tail.vld;
    end
    if (accept) begin
      len_r <= len_sat;
    end
    out_data_r.char_code     <= alpha_r[tail.rem[itcs_pkg::RADIX_W-1:3]][tail.rem[2:0]];
    out_data_r.char_position <= pos_full[itcs_pkg::POS_W-1:0];
    out_data_r.is_last       <= (out_cnt_r == len_m1);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ITCS_ASSERT_NOW(a_out_in_item, out_valid, busy, "character shown outside an item")
  `ITCS_ASSERT_NEXT(a_busy_on_take, start && !busy && (in_data.string_length != '0), busy,
                    "item with characters did not raise busy")
  `ITCS_ASSERT_NEXT(a_empty_item, start && !busy && (in_data.string_length == '0), !busy,
                    "empty item raised busy")
  `ITCS_ASSERT_NEXT(a_last_ends, out_valid && out_data.is_last, !busy,
                    "busy held after last character")
  `ITCS_ASSERT_NEXT(a_no_gap, out_valid && !out_data.is_last, out_valid,
                    "gap in character stream")

endmodule

`default_nettype wire

### tb/tb_index_to_charset_string.sv
// Testbench for index_to_charset_string: random and corner-case indexes vs a base-N model.
`timescale 1ns / 100ps

module tb_index_to_charset_string;
  import itcs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PAUSE  = 30;   // longer than the worst case busy time
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    in_t item;
    bit  wait_drain;   // hold off until every expected character has come
  } pending_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_data = '0;

  // predictor copy of the configuration
  logic [RADIX_W-1:0]   alpha_size = ALPHA_SIZE_RST;
  logic [IDX_W-1:0]     alpha_w [ALPHA_WORDS];

  pending_item_t        pending_q [$];
  out_t                 exp_chars [$];
  bit                   gaps_on = 1'b1;
  int unsigned          gap_left = 0;
  int unsigned          cycles = 0;
  int unsigned          errors = 0;
  int unsigned          n_items = 0;
  int unsigned          n_chars = 0;
  int unsigned          n_empty = 0;
  int unsigned          n_clipped = 0;
  int unsigned          n_settings = 0;

  index_to_charset_string u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Expected characters of one index, last position first.
  function automatic void predict_string(in_t it);
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] radix;
    logic [IDX_W-1:0] digit;
    int               n;
    out_t             c;
    rest  = it.key_index;
    radix = (alpha_size == '0) ? IDX_W'(RADIX_MIN) :
            (alpha_size > RADIX_MAX) ? IDX_W'(RADIX_MAX) : IDX_W'(alpha_size);
    n = (it.string_length > MAX_LEN) ? int'(MAX_LEN) : int'(it.string_length);
    if (n == 0) n_empty++;
    if (it.string_length > MAX_LEN) n_clipped++;
    for (int p = n - 1; p >= 0; p--) begin
      digit           = rest % radix;
      rest            = rest / radix;
      c.char_code     = alpha_w[digit[5:3]][{digit[2:0], 3'b000} +: CHAR_W];
      c.char_position = POS_W'(p);
      c.is_last       = (p == 0);
      exp_chars.push_back(c);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_string(in_data);
        n_items++;
      end
      if (start && busy) begin
        // held until the transfer
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].wait_drain && exp_chars.size() != 0)) begin
        in_data  <= pending_q[0].item;
        start    <= 1'b1;
        gap_left <= pick_gap();
        void'(pending_q.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (exp_chars.size() == 0) begin
        $error("unexpected character %0h at position %0d", out_data.char_code,
               out_data.char_position);
        errors++;
      end else begin
        want = exp_chars.pop_front();
        n_chars++;
        if (out_data.char_code !== want.char_code) begin
          $error("char_code: expected %0h, got %0h", want.char_code, out_data.char_code);
          errors++;
        end
        if (out_data.char_position !== want.char_position) begin
          $error("char_position: expected %0d, got %0d", want.char_position,
                 out_data.char_position);
          errors++;
        end
        if (out_data.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_data.is_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One register transfer; valid is left high so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx) inside
      REG_ALPHA_SIZE:  alpha_size = data[RADIX_W-1:0];
      REG_ALPHA_WORD0, REG_ALPHA_WORD1, REG_ALPHA_WORD2,
      REG_ALPHA_WORD3, REG_ALPHA_WORD4, REG_ALPHA_WORD5:
        alpha_w[idx - REG_ALPHA_WORD0] = data;
      default: ;   // unmapped index, dropped
    endcase
  endtask

  // Wait until the block has drained, with margin for zero-length items.
  task automatic settle();
    while (pending_q.size() != 0 || start || exp_chars.size() != 0 || busy)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
    n_settings++;
  endtask

  task automatic queue_item(input logic [IDX_W-1:0] key, input logic [LEN_W-1:0] len,
                            input bit drain);
    pending_item_t p;
    p.item.key_index     = key;
    p.item.string_length = len;
    p.wait_drain         = drain;
    pending_q.push_back(p);
  endtask

  function automatic logic [IDX_W-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return IDX_W'($urandom_range(0, 3000));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return MAX_LEN;
    if (r == 2) return LEN_W'($urandom_range(17, 31));
    return LEN_W'($urandom_range(1, 16));
  endfunction

  function automatic logic [RADIX_W-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return RADIX_W'($urandom_range(49, 63));
    if (r == 2) return RADIX_MIN;
    if (r == 3) return RADIX_MAX;
    return RADIX_W'($urandom_range(2, 47));
  endfunction

  initial begin
    logic [IDX_W-1:0] words [ALPHA_WORDS];
    byte              ch;
    for (int w = 0; w < ALPHA_WORDS; w++) alpha_w[w] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset alphabet: all zero characters, size 26
    queue_item(64'h0123_4567_89ab_cdef, 5'd5, 1'b0);
    queue_item('1, 5'd0, 1'b0);
    settle();

    // printable 48-character alphabet, largest radix
    for (int k = 0; k < ALPHA_CHARS; k++) begin
      ch = (k < 10) ? byte'("0" + k) : (k < 36) ? byte'("a" + k - 10) : byte'("A" + k - 36);
      words[k / 8][(k % 8) * 8 +: 8] = ch;
    end
    write_reg(REG_ALPHA_SIZE, IDX_W'(RADIX_MAX));
    for (int w = 0; w < ALPHA_WORDS; w++)
      write_reg(CFG_IDX_W'(REG_ALPHA_WORD0 + w), words[w]);
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    queue_item('0, MAX_LEN, 1'b0);
    queue_item('1, MAX_LEN, 1'b0);
    queue_item('1, 5'd1, 1'b0);
    queue_item(64'd47, 5'd1, 1'b0);
    queue_item(64'd48, 5'd2, 1'b0);
    queue_item(64'h1234, 5'd0, 1'b0);
    queue_item({$urandom, $urandom}, 5'd17, 1'b0);
    queue_item({$urandom, $urandom}, 5'd31, 1'b0);
    queue_item(64'haaaa_aaaa_aaaa_aaaa, 5'd12, 1'b0);
    queue_item(64'h5555_5555_5555_5555, 5'd12, 1'b1);
    settle();

    // size zero behaves as radix one
    write_reg(REG_ALPHA_SIZE, '0);
    cfg_valid <= 1'b0;
    queue_item('1, MAX_LEN, 1'b0);
    queue_item({$urandom, $urandom}, 5'd3, 1'b0);
    settle();

    // size above the table is clipped to 48
    write_reg(REG_ALPHA_SIZE, 64'd63);
    cfg_valid <= 1'b0;
    queue_item('1, MAX_LEN, 1'b0);
    queue_item({$urandom, $urandom}, 5'd8, 1'b0);
    settle();

    write_reg(REG_ALPHA_SIZE, IDX_W'(RADIX_MIN));
    cfg_valid <= 1'b0;
    queue_item({$urandom, $urandom}, 5'd4, 1'b0);
    settle();

    // binary: bottom 16 bits of the index visible in a 16-char string
    write_reg(REG_ALPHA_SIZE, 64'd2);
    write_reg(REG_ALPHA_WORD0, 64'h3130);
    cfg_valid <= 1'b0;
    queue_item(64'h8000_0000_0000_ffff, MAX_LEN, 1'b0);
    settle();

    // random phases, every register rewritten each time
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = (ph % 3 != 1);
      write_reg(REG_ALPHA_SIZE, (ph == 0) ? IDX_W'(RADIX_MAX) : IDX_W'(rand_size()));
      for (int w = 0; w < ALPHA_WORDS; w++)
        write_reg(CFG_IDX_W'(REG_ALPHA_WORD0 + w), {$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
      cfg_valid <= 1'b0;
      for (int i = 0; i < 17; i++)
        queue_item(rand_key(), rand_len(), $urandom_range(0, 19) == 0);
      settle();
    end

    if (exp_chars.size() != 0) begin
      $error("%0d expected characters never arrived", exp_chars.size());
      errors++;
    end
    $display("Converted %0d indexes into %0d checked characters over %0d alphabet settings",
             n_items, n_chars, n_settings);
    $display("Zero-length items: %0d, over-long lengths clipped: %0d", n_empty, n_clipped);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### index_to_charset_string.f
+incdir+src
src/itcs_pkg.sv
src/itcs_cell.sv
src/itcs_chain.sv
src/index_to_charset_string.sv
tb/tb_index_to_charset_string.sv
